// ===== hw/rtl/instrument_bank_program_lookup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Instrument bank program lookup: assertion macros
// Shared concurrent assertion macros; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef INSTRUMENT_BANK_PROGRAM_LOOKUP_UNIT_DEFINES_SVH
`define INSTRUMENT_BANK_PROGRAM_LOOKUP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define IBPL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ibpl assertion failed");
`define IBPL_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ibpl assertion failed");
`else
`define IBPL_ASSERT_IMP(label, clk, rst_n, pre, post)
`define IBPL_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== hw/rtl/ibpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Instrument bank program lookup package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibpl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_STORED  = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_LOOKUP  = 2'd2;

    localparam logic [1:0] KIND_FULL_BANK = 2'd0;
    localparam logic [1:0] KIND_LOW_BANK  = 2'd1;
    localparam logic [1:0] KIND_PROGRAM   = 2'd2;

    localparam int DRUM_BIT = 31;

    typedef struct packed {
        logic full_bank;
        logic low_bank;
        logic program_only;
    } hit_t;

endpackage

// ===== hw/rtl/ibpl_table.sv =====
// ----------------------------------------------------------------------------
// Instrument entry table
// Bank word and program memory with one write port and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibpl_table #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_bank,
    input  logic [7:0]       wr_prog,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_bank,
    output logic [7:0]       rd_prog
);

    logic [31:0] bank_mem [DEPTH];
    logic [7:0]  prog_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank_mem[wr_addr] <= wr_bank;
            prog_mem[wr_addr] <= wr_prog;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_bank <= bank_mem[rd_addr];
            rd_prog <= prog_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ibpl_match.sv =====
// ----------------------------------------------------------------------------
// Entry compare unit
// Grades one table entry against the patch word into the three tiers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibpl_match (
    input  logic [31:0]   entry_bank,
    input  logic [7:0]    entry_prog,
    input  logic [31:0]   patch,
    output ibpl_pkg::hit_t hit
);

    import ibpl_pkg::*;

    logic prog_eq;

    assign prog_eq = (entry_prog == patch[7:0]);

    always_comb begin
        hit.full_bank    = prog_eq && (entry_bank[23:16] == patch[23:16])
                                   && (entry_bank[7:0] == patch[15:8]);
        hit.low_bank     = prog_eq && (entry_bank[6:0] == patch[14:8]);
        hit.program_only = prog_eq;
    end

endmodule

// ===== hw/rtl/instrument_bank_program_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Instrument bank program lookup unit
// Appends instrument entries to a table and looks up patches by tier.
// ----------------------------------------------------------------------------
//  Channel  Ports  Direction  Carries
//  input    s_*    in         opcode, entry bank and program, query patch
//  result   m_*    out        status, found, entry index, match kind, drum kit
//
//  An append passes through the done state to the output register.
//  A lookup scans the stored entries, and none on an empty table: the single
//  table read port delivers one entry per cycle to the shared compare unit.
//  Reset clears the entry count but not the table; the table needs no clearing pass.
//  The next item is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "instrument_bank_program_lookup_unit_defines.svh"

module instrument_bank_program_lookup_unit #(
    parameter int TABLE_DEPTH = ibpl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_entry_bank,
    input  logic [7:0]  s_entry_program,
    input  logic [31:0] s_query_patch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [7:0]  m_entry_index,
    output logic [1:0]  m_match_kind,
    output logic        m_drum_kit
);

    import ibpl_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             op_reg, full_reg;
    logic [31:0]      patch_reg;
    logic             pipe_valid_reg;
    logic [IDX_W-1:0] pipe_idx_reg;
    logic             have_reg [3];
    logic [IDX_W-1:0] best_idx_reg [3];
    logic             best_drum_reg [3];

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic             m_found_reg;
    logic [7:0]       m_entry_index_reg;
    logic [1:0]       m_match_kind_reg;
    logic             m_drum_kit_reg;

    logic             accept, table_full, wr_en, issue, load_out;
    logic [31:0]      rd_bank;
    logic [7:0]       rd_prog;
    hit_t             hit;

    logic [1:0]       res_status, res_kind;
    logic             res_found, res_drum;
    logic [IDX_W-1:0] res_idx;
    logic [IDX_W+7:0] res_idx_wide;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign wr_en      = accept && (s_opcode == OP_APPEND) && !table_full;
    assign issue      = (state_reg == ST_SCAN) && (addr_reg < count_reg);
    assign load_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    ibpl_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_bank (s_entry_bank),
        .wr_prog (s_entry_program),
        .rd_en   (issue),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_bank (rd_bank),
        .rd_prog (rd_prog)
    );

    ibpl_match u_match (
        .entry_bank (rd_bank),
        .entry_prog (rd_prog),
        .patch      (patch_reg),
        .hit        (hit)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    addr_next = '0;
                    if (s_opcode == OP_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                        if (!table_full) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                end else if (!pipe_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res_found = 1'b0;
        res_idx   = '0;
        res_kind  = KIND_FULL_BANK;
        res_drum  = patch_reg[DRUM_BIT];
        if (op_reg == OP_APPEND) begin
            res_status = full_reg ? STATUS_FULL : STATUS_STORED;
            res_drum   = 1'b0;
        end else begin
            res_status = STATUS_LOOKUP;
            if (have_reg[0]) begin
                res_found = 1'b1;
                res_idx   = best_idx_reg[0];
                res_kind  = KIND_FULL_BANK;
                res_drum  = patch_reg[DRUM_BIT] | best_drum_reg[0];
            end else if (have_reg[1]) begin
                res_found = 1'b1;
                res_idx   = best_idx_reg[1];
                res_kind  = KIND_LOW_BANK;
                res_drum  = patch_reg[DRUM_BIT] | best_drum_reg[1];
            end else if (have_reg[2]) begin
                res_found = 1'b1;
                res_idx   = best_idx_reg[2];
                res_kind  = KIND_PROGRAM;
                res_drum  = patch_reg[DRUM_BIT] | best_drum_reg[2];
            end
        end
        res_idx_wide = {8'd0, res_idx};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int t = 0; t < 3; t++) begin
                have_reg[t] <= 1'b0;
            end
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pipe_valid_reg <= issue;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                for (int t = 0; t < 3; t++) begin
                    have_reg[t] <= 1'b0;
                end
            end else if (pipe_valid_reg) begin
                if (hit.full_bank) begin
                    have_reg[0] <= 1'b1;
                end
                if (hit.low_bank) begin
                    have_reg[1] <= 1'b1;
                end
                if (hit.program_only) begin
                    have_reg[2] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        pipe_idx_reg <= addr_reg[IDX_W-1:0];
        if (accept) begin
            op_reg    <= s_opcode;
            full_reg  <= table_full;
            patch_reg <= s_query_patch;
        end
        if (pipe_valid_reg) begin
            if (hit.full_bank) begin
                best_idx_reg[0]  <= pipe_idx_reg;
                best_drum_reg[0] <= rd_bank[DRUM_BIT];
            end
            if (hit.low_bank) begin
                best_idx_reg[1]  <= pipe_idx_reg;
                best_drum_reg[1] <= rd_bank[DRUM_BIT];
            end
            if (hit.program_only) begin
                best_idx_reg[2]  <= pipe_idx_reg;
                best_drum_reg[2] <= rd_bank[DRUM_BIT];
            end
        end
        if (load_out) begin
            m_status_reg      <= res_status;
            m_found_reg       <= res_found;
            m_entry_index_reg <= res_idx_wide[7:0];
            m_match_kind_reg  <= res_kind;
            m_drum_kit_reg    <= res_drum;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found       = m_found_reg;
    assign m_entry_index = m_entry_index_reg;
    assign m_match_kind  = m_match_kind_reg;
    assign m_drum_kit    = m_drum_kit_reg;

    `IBPL_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `IBPL_ASSERT_IMP(a_pipe_in_scan, aclk, aresetn, pipe_valid_reg, state_reg == ST_SCAN)
    `IBPL_ASSERT_NXT(a_append_grows, aclk, aresetn, wr_en, count_reg == $past(count_reg) + CNT_W'(1))
    `IBPL_ASSERT_IMP(a_miss_clean, aclk, aresetn, m_valid_reg && !m_found_reg, m_entry_index_reg == 8'd0 && m_match_kind_reg == KIND_FULL_BANK)

endmodule

// ===== tb/tb_instrument_bank_program_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Instrument bank program lookup unit: self-checking testbench
// Appends instrument entries and looks up patches through the valid/ready
// channels. A scoreboard keeps its own copy of the table and works out the
// tier, index and drum-kit flag of every lookup. It compares each returned
// item with the oldest expected one. The table is filled past its depth so
// that dropped appends are covered too.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_instrument_bank_program_lookup_unit;

    import ibpl_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] entry_index;
        logic [1:0] match_kind;
        logic       drum_kit;
    } lookup_result_t;

    class lookup_scoreboard;
        logic [31:0]    bank_words[$];
        logic [7:0]     program_numbers[$];
        lookup_result_t expected_results[$];
        int errors;
        int n_stored;
        int n_dropped;
        int n_full_bank;
        int n_low_bank;
        int n_program;
        int n_missed;

        function void note_input(logic op, logic [31:0] bank, logic [7:0] prog,
                                 logic [31:0] patch);
            lookup_result_t r;
            hit_t           hits;
            int             full_idx;
            int             low_idx;
            int             prog_idx;
            r = '0;
            hits = '0;
            full_idx = 0;
            low_idx = 0;
            prog_idx = 0;
            if (op == OP_APPEND) begin
                if (bank_words.size() < DEPTH) begin
                    bank_words.push_back(bank);
                    program_numbers.push_back(prog);
                    r.status = STATUS_STORED;
                    n_stored++;
                end else begin
                    r.status = STATUS_FULL;
                    n_dropped++;
                end
            end else begin
                r.status = STATUS_LOOKUP;
                r.drum_kit = patch[DRUM_BIT];
                foreach (bank_words[i]) begin
                    if (program_numbers[i] == patch[7:0]) begin
                        if (bank_words[i][23:16] == patch[23:16] &&
                            bank_words[i][7:0] == patch[15:8]) begin
                            hits.full_bank = 1'b1;
                            full_idx = i;
                        end
                        if (bank_words[i][6:0] == patch[14:8]) begin
                            hits.low_bank = 1'b1;
                            low_idx = i;
                        end
                        hits.program_only = 1'b1;
                        prog_idx = i;
                    end
                end
                r.found = 1'b1;
                if (hits.full_bank) begin
                    r.entry_index = full_idx[7:0];
                    r.match_kind = KIND_FULL_BANK;
                    n_full_bank++;
                end else if (hits.low_bank) begin
                    r.entry_index = low_idx[7:0];
                    r.match_kind = KIND_LOW_BANK;
                    n_low_bank++;
                end else if (hits.program_only) begin
                    r.entry_index = prog_idx[7:0];
                    r.match_kind = KIND_PROGRAM;
                    n_program++;
                end else begin
                    r.found = 1'b0;
                    n_missed++;
                end
                if (r.found && bank_words[r.entry_index][DRUM_BIT]) begin
                    r.drum_kit = 1'b1;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: status %0d found %0d index %0d kind %0d drum %0d",
                         $time, got.status, got.found, got.entry_index, got.match_kind,
                         got.drum_kit);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch: expected status %0d found %0d index %0d kind %0d drum %0d, actual status %0d found %0d index %0d kind %0d drum %0d",
                             $time, want.status, want.found, want.entry_index,
                             want.match_kind, want.drum_kit, got.status, got.found,
                             got.entry_index, got.match_kind, got.drum_kit);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = OP_APPEND;
    logic [31:0] s_entry_bank = '0;
    logic [7:0]  s_entry_program = '0;
    logic [31:0] s_query_patch = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [7:0]  m_entry_index;
    logic [1:0]  m_match_kind;
    logic        m_drum_kit;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    lookup_scoreboard sb = new();

    instrument_bank_program_lookup_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_entry_bank   (s_entry_bank),
        .s_entry_program(s_entry_program),
        .s_query_patch  (s_query_patch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found        (m_found),
        .m_entry_index  (m_entry_index),
        .m_match_kind   (m_match_kind),
        .m_drum_kit     (m_drum_kit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_status, m_found, m_entry_index, m_match_kind, m_drum_kit});
        end
    end

    task automatic send_item(input logic op, input logic [31:0] bank,
                             input logic [7:0] prog, input logic [31:0] patch);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_entry_bank    <= bank;
        s_entry_program <= prog;
        s_query_patch   <= patch;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, bank, prog, patch);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h12;
            2: return 8'h80;
            3: return 8'h92;
            4: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_program();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(3));
            6: return 8'hFF;
            7: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_item(input int append_pct);
        logic [31:0] bank;
        logic [31:0] patch;
        logic [31:0] e_bank;
        logic [7:0]  prog;
        int          k;
        bank = $urandom;
        bank[23:16] = pick_byte();
        bank[7:0] = pick_byte();
        prog = pick_program();
        patch = $urandom;
        if ($urandom_range(99) < append_pct) begin
            send_item(OP_APPEND, bank, prog, patch);
        end else begin
            if (sb.bank_words.size() != 0 && $urandom_range(99) < 80) begin
                k = $urandom_range(sb.bank_words.size() - 1);
                e_bank = sb.bank_words[k];
                patch[7:0] = sb.program_numbers[k];
                case ($urandom_range(2))
                    0: begin
                        patch[23:16] = e_bank[23:16];
                        patch[15:8] = e_bank[7:0];
                    end
                    1: patch[14:8] = e_bank[6:0];
                    default: ;
                endcase
            end else begin
                patch[7:0] = pick_program();
            end
            send_item(OP_LOOKUP, bank, prog, patch);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 17;
        rx_idle_pct = 55;
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_0000);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'hFFFF_FFFF);
        send_item(OP_APPEND, 32'h0000_0000, 8'h00, 32'h0);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 8'hFF, 32'h0);
        send_item(OP_APPEND, 32'h00AB_0012, 8'h05, 32'h0);
        send_item(OP_APPEND, 32'h80CD_0092, 8'h05, 32'h0);
        send_item(OP_APPEND, 32'h7F00_0034, 8'h05, 32'h0);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h00AB_1205);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h00CD_9205);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_1205);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h00EE_5505);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h80EE_5505);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h0000_0007);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h00FF_FFFF);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h7F00_0000);
        send_item(OP_APPEND, 32'h00AB_0012, 8'h05, 32'h0);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 32'h00AB_1205);
        drain_results();

        repeat (180) random_item(60);
        drain_results();

        tx_idle_pct = 55;
        rx_idle_pct = 17;
        repeat (180) random_item(60);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (180) random_item(40);
        drain_results();
        repeat (DEPTH + 16) @(posedge aclk);

        $display("Run covered %0d stored and %0d dropped appends on a table of depth %0d.",
                 sb.n_stored, sb.n_dropped, DEPTH);
        $display("Lookups: %0d full bank, %0d low bank, %0d program only, %0d without a match.",
                 sb.n_full_bank, sb.n_low_bank, sb.n_program, sb.n_missed);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("tb_instrument_bank_program_lookup_unit OK");
        end else begin
            $display("tb_instrument_bank_program_lookup_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout with %0d items outstanding", $time, sb.expected_results.size());
        $display("tb_instrument_bank_program_lookup_unit NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ibpl_pkg.sv
hw/rtl/ibpl_table.sv
hw/rtl/ibpl_match.sv
hw/rtl/instrument_bank_program_lookup_unit.sv
tb/tb_instrument_bank_program_lookup_unit.sv
